[rtl/stepper_position_follower_macros.svh]
// Assertion macros for the stepper position follower checker.
// Depends on nothing; included by the checker file.
`ifndef STEPPER_POSITION_FOLLOWER_MACROS_SVH
`define STEPPER_POSITION_FOLLOWER_MACROS_SVH

// Same-cycle implication, disabled while rst_n is low
`define SPF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while rst_n is low
`define SPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

[rtl/spf_pkg.sv]
// Shared types and constants for the stepper position follower.
// Depends on nothing; imported by the core, the top level and the checker.
`timescale 1ns / 1ps

package spf_pkg;

    // Default widths
    localparam int LEVEL_BITS_DEF = 10;
    localparam int DELAY_BITS_DEF = 16;

    // Register reset values
    localparam int DEADBAND_RST     = 20;
    localparam int PRECISION_RST    = 5;
    localparam int CUSHION_RST      = 50;
    localparam int ACCELERATION_RST = 1;
    localparam int BASE_DELAY_RST   = 1000;
    localparam int MIN_PULSE_RST    = 5;

    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_DEADBAND     = 3'd0,
        REG_PRECISION    = 3'd1,
        REG_CUSHION      = 3'd2,
        REG_ACCELERATION = 3'd3,
        REG_BASE_DELAY   = 3'd4,
        REG_MIN_PULSE    = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_CW   = 2'd1,
        ST_CCW  = 2'd2
    } t_motion;

    // Control part of one result beat
    typedef struct packed {
        t_motion motion_state;
        logic    direction_cw;
        logic    driver_enable;
        logic    step_pulse;
    } t_ctl;

endpackage

[rtl/spf_in_if.sv]
// Input channel of the stepper position follower: one sample pair per beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface spf_in_if #(
    parameter int LEVEL_BITS = 10
);
    logic                  valid;
    logic                  ready;
    logic [LEVEL_BITS-1:0] order_level;
    logic [LEVEL_BITS-1:0] position_level;

    modport source (output valid, output order_level, output position_level, input ready);
    modport sink   (input valid, input order_level, input position_level, output ready);
endinterface

[rtl/spf_out_if.sv]
// Result channel of the stepper position follower: one motion decision per beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface spf_out_if #(
    parameter int LEVEL_BITS = 10,
    parameter int DELAY_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   motion_state;
    logic                         direction_cw;
    logic                         driver_enable;
    logic                         step_pulse;
    logic [DELAY_BITS-1:0]        half_period;
    logic signed [LEVEL_BITS:0]   level_difference;

    modport source (output valid, output motion_state, output direction_cw,
                    output driver_enable, output step_pulse, output half_period,
                    output level_difference, input ready);
    modport sink   (input valid, input motion_state, input direction_cw,
                    input driver_enable, input step_pulse, input half_period,
                    input level_difference, output ready);
endinterface

[rtl/spf_core.sv]
// Motion decision core: configuration registers, follower state, and the
// single-pass next-result logic. Depends on spf_pkg.
`timescale 1ns / 1ps

module spf_core #(
    parameter int LEVEL_BITS = spf_pkg::LEVEL_BITS_DEF,
    parameter int DELAY_BITS = spf_pkg::DELAY_BITS_DEF,
    parameter int CFG_BITS   = (LEVEL_BITS > DELAY_BITS) ? LEVEL_BITS : DELAY_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [spf_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_BITS-1:0]               i_cfg_data,
    input  logic                              i_advance,
    input  logic [LEVEL_BITS-1:0]             i_order_level,
    input  logic [LEVEL_BITS-1:0]             i_position_level,
    output spf_pkg::t_ctl                     o_ctl,
    output logic [DELAY_BITS-1:0]             o_half_period,
    output logic signed [LEVEL_BITS:0]        o_level_difference
);
    import spf_pkg::*;

    localparam logic [DELAY_BITS-1:0] DELAY_MAX = {DELAY_BITS{1'b1}};

    // Configuration registers
    logic [LEVEL_BITS-1:0] r_deadband;
    logic [LEVEL_BITS-1:0] r_precision;
    logic [LEVEL_BITS-1:0] r_cushion;
    logic [DELAY_BITS-1:0] r_acceleration;
    logic [DELAY_BITS-1:0] r_base_delay;
    logic [DELAY_BITS-1:0] r_min_pulse;

    // Follower state
    t_motion               r_state,      n_state;
    logic                  r_near_start, n_near_start;
    logic                  r_near_end,   n_near_end;
    logic [LEVEL_BITS-1:0] r_start_pos,  n_start_pos;
    logic [LEVEL_BITS-1:0] r_end_pos,    n_end_pos;
    logic [DELAY_BITS-1:0] r_step_delay, n_step_delay;

    logic                  w_diff_neg;
    logic [LEVEL_BITS-1:0] w_mag;
    logic [DELAY_BITS:0]   w_sum;

    function automatic logic [LEVEL_BITS-1:0] f_dist(
        input logic [LEVEL_BITS-1:0] a,
        input logic [LEVEL_BITS-1:0] b
    );
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband     <= LEVEL_BITS'(DEADBAND_RST);
            r_precision    <= LEVEL_BITS'(PRECISION_RST);
            r_cushion      <= LEVEL_BITS'(CUSHION_RST);
            r_acceleration <= DELAY_BITS'(ACCELERATION_RST);
            r_base_delay   <= DELAY_BITS'(BASE_DELAY_RST);
            r_min_pulse    <= DELAY_BITS'(MIN_PULSE_RST);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_DEADBAND:     r_deadband     <= i_cfg_data[LEVEL_BITS-1:0];
                REG_PRECISION:    r_precision    <= i_cfg_data[LEVEL_BITS-1:0];
                REG_CUSHION:      r_cushion      <= i_cfg_data[LEVEL_BITS-1:0];
                REG_ACCELERATION: r_acceleration <= i_cfg_data[DELAY_BITS-1:0];
                REG_BASE_DELAY:   r_base_delay   <= i_cfg_data[DELAY_BITS-1:0];
                REG_MIN_PULSE:    r_min_pulse    <= i_cfg_data[DELAY_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Decide state, cushions and step delay for the current sample
    always_comb begin
        o_level_difference = $signed({1'b0, i_order_level}) - $signed({1'b0, i_position_level});
        w_diff_neg   = i_order_level < i_position_level;
        w_mag        = f_dist(i_order_level, i_position_level);

        n_state      = r_state;
        n_near_start = r_near_start;
        n_near_end   = r_near_end;
        n_start_pos  = r_start_pos;
        n_end_pos    = r_end_pos;
        n_step_delay = r_step_delay;

        priority if (!w_diff_neg && w_mag > r_deadband) begin
            n_state      = ST_CW;
            n_near_start = f_dist(i_position_level, r_start_pos) <= r_cushion;
            n_near_end   = f_dist(i_position_level, r_end_pos) <= r_cushion;
        end else if (w_diff_neg && w_mag > r_deadband) begin
            n_state      = ST_CCW;
            n_near_start = f_dist(i_position_level, r_start_pos) <= r_cushion;
            n_near_end   = f_dist(i_position_level, r_end_pos) <= r_cushion;
        end else begin
            // Within the deadband: idle within precision, else hold state; latch endpoints
            if (w_mag <= r_precision) begin
                n_state = ST_IDLE;
            end
            n_start_pos = i_position_level;
            n_end_pos   = i_order_level;
        end

        // Ramp the delay, saturating at both ends
        w_sum = {1'b0, r_step_delay} + {1'b0, r_acceleration};
        priority if (n_state == ST_IDLE) begin
            n_step_delay = r_base_delay;
        end else if (n_near_start) begin
            n_step_delay = (r_step_delay > r_acceleration) ? (r_step_delay - r_acceleration)
                                                           : '0;
        end else if (n_near_end) begin
            n_step_delay = w_sum[DELAY_BITS] ? DELAY_MAX : w_sum[DELAY_BITS-1:0];
        end else begin
            n_step_delay = r_step_delay;
        end

        o_ctl.motion_state  = n_state;
        o_ctl.direction_cw  = n_state == ST_CW;
        o_ctl.driver_enable = n_state != ST_IDLE;
        o_ctl.step_pulse    = n_state != ST_IDLE;
        if (n_state == ST_IDLE) begin
            o_half_period = '0;
        end else begin
            o_half_period = (n_step_delay <= r_min_pulse) ? r_base_delay : n_step_delay;
        end
    end

    // Commit state when the sample moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_near_start <= 1'b0;
            r_near_end   <= 1'b0;
            r_start_pos  <= '0;
            r_end_pos    <= '0;
            r_step_delay <= DELAY_BITS'(BASE_DELAY_RST);
        end else if (i_advance) begin
            r_state      <= n_state;
            r_near_start <= n_near_start;
            r_near_end   <= n_near_end;
            r_start_pos  <= n_start_pos;
            r_end_pos    <= n_end_pos;
            r_step_delay <= n_step_delay;
        end
    end

endmodule

[rtl/stepper_position_follower.sv]
// Stepper position follower top level: input register, decision core and
// result register. Depends on spf_pkg, spf_in_if, spf_out_if and spf_core.
`timescale 1ns / 1ps

// Takes one sample pair (commanded and measured level) per beat and returns one
// motion decision per sample: state, direction, driver enable, step pulse and
// step half-period. A new sample can be taken every clock cycle while the result
// side is not stalled. A sample is held in the input register from the edge that
// accepts it, and its result is loaded into the result register at the edge that
// advances it, once the result slot is free or being drained. The follower state
// is updated at that same edge, which sets the one-sample-per-cycle rate. The
// input side keeps taking beats while a result waits, up to the one held in the
// input register. Configuration writes must only be issued while no sample is in flight.
module stepper_position_follower #(
    parameter int LEVEL_BITS = spf_pkg::LEVEL_BITS_DEF,
    parameter int DELAY_BITS = spf_pkg::DELAY_BITS_DEF,
    parameter int CFG_BITS   = (LEVEL_BITS > DELAY_BITS) ? LEVEL_BITS : DELAY_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [spf_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_BITS-1:0]               i_cfg_data,
    spf_in_if.sink                            i_sample,
    spf_out_if.source                         o_result
);
    import spf_pkg::*;

    logic                       r_in_valid;
    logic [LEVEL_BITS-1:0]      r_order_level;
    logic [LEVEL_BITS-1:0]      r_position_level;

    logic                       r_out_valid;
    t_ctl                       r_ctl;
    logic [DELAY_BITS-1:0]      r_half_period;
    logic signed [LEVEL_BITS:0] r_level_difference;

    logic                       w_advance;
    t_ctl                       w_ctl;
    logic [DELAY_BITS-1:0]      w_half_period;
    logic signed [LEVEL_BITS:0] w_level_difference;

    // Move a sample forward when the result slot is free or being drained
    assign w_advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_sample.ready = !r_in_valid || w_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_order_level    <= i_sample.order_level;
            r_position_level <= i_sample.position_level;
        end
    end

    spf_core #(
        .LEVEL_BITS (LEVEL_BITS),
        .DELAY_BITS (DELAY_BITS),
        .CFG_BITS   (CFG_BITS)
    ) u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_advance          (w_advance),
        .i_order_level      (r_order_level),
        .i_position_level   (r_position_level),
        .o_ctl              (w_ctl),
        .o_half_period      (w_half_period),
        .o_level_difference (w_level_difference)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_ctl              <= w_ctl;
            r_half_period      <= w_half_period;
            r_level_difference <= w_level_difference;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.motion_state     = r_ctl.motion_state;
    assign o_result.direction_cw     = r_ctl.direction_cw;
    assign o_result.driver_enable    = r_ctl.driver_enable;
    assign o_result.step_pulse       = r_ctl.step_pulse;
    assign o_result.half_period      = r_half_period;
    assign o_result.level_difference = r_level_difference;

endmodule

[rtl/spf_chk.sv]
// Port-level checker for the stepper position follower, bound to the top level.
// Depends on spf_pkg and stepper_position_follower_macros.svh.
`timescale 1ns / 1ps
`include "stepper_position_follower_macros.svh"

module spf_chk #(
    parameter int LEVEL_BITS = spf_pkg::LEVEL_BITS_DEF,
    parameter int DELAY_BITS = spf_pkg::DELAY_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [1:0]            i_motion_state,
    input logic                  i_direction_cw,
    input logic                  i_driver_enable,
    input logic                  i_step_pulse,
    input logic [DELAY_BITS-1:0] i_half_period,
    input logic [LEVEL_BITS:0]   i_level_difference
);
    import spf_pkg::*;

    // A result beat never drops before it is taken
    `SPF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // Nothing shows at the output right after reset
    `SPF_ASSERT_NEXT(a_rst_empty, i_clk, 1'b1, !i_rst_n, !i_out_valid)

    // Idle beats carry no pulse and no half-period
    `SPF_ASSERT_NOW(a_idle_quiet, i_clk, i_rst_n, i_out_valid && (i_motion_state == ST_IDLE), !i_step_pulse && !i_driver_enable && !i_direction_cw && (i_half_period == '0))

    // A moving beat has its pins in line with the state, and a nonzero error
    `SPF_ASSERT_NOW(a_move_pins, i_clk, i_rst_n, i_out_valid && (i_motion_state != ST_IDLE), i_step_pulse && i_driver_enable && (i_direction_cw == (i_motion_state == ST_CW)) && (i_level_difference != '0))

endmodule

bind stepper_position_follower spf_chk #(
    .LEVEL_BITS (LEVEL_BITS),
    .DELAY_BITS (DELAY_BITS)
) u_spf_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_result.valid),
    .i_out_ready        (o_result.ready),
    .i_motion_state     (o_result.motion_state),
    .i_direction_cw     (o_result.direction_cw),
    .i_driver_enable    (o_result.driver_enable),
    .i_step_pulse       (o_result.step_pulse),
    .i_half_period      (o_result.half_period),
    .i_level_difference (o_result.level_difference)
);

[dv/tb_stepper_position_follower.sv]
// Self-checking testbench for the stepper position follower.
// Depends on spf_pkg, spf_in_if, spf_out_if and the stepper_position_follower RTL.
`timescale 1ns / 1ps

module tb_stepper_position_follower;
    import spf_pkg::*;

    localparam int LEVEL_BITS = LEVEL_BITS_DEF;
    localparam int DELAY_BITS = DELAY_BITS_DEF;
    localparam int LEVEL_MAX  = (1 << LEVEL_BITS) - 1;
    localparam int DELAY_MAX  = (1 << DELAY_BITS) - 1;

    // Unused register slots, written to show they change nothing
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

    // Settings used to pick a register set for a random phase
    localparam int SET_MODERATE  = 0;
    localparam int SET_FAST_RAMP = 1;
    localparam int SET_FLAT_RAMP = 2;

    localparam int PRINT_CAP = 200;

    typedef struct {
        t_motion                motion;
        logic                   cw;
        logic                   enable;
        logic                   pulse;
        logic [DELAY_BITS-1:0]  half;
        logic signed [LEVEL_BITS:0] diff;
    } t_decision;

    bit   i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [DELAY_BITS-1:0]   i_cfg_data;

    spf_in_if  #(.LEVEL_BITS(LEVEL_BITS)) sample_ch ();
    spf_out_if #(.LEVEL_BITS(LEVEL_BITS), .DELAY_BITS(DELAY_BITS)) result_ch ();

    stepper_position_follower #(
        .LEVEL_BITS(LEVEL_BITS),
        .DELAY_BITS(DELAY_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (sample_ch),
        .o_result   (result_ch)
    );

    // Register copies
    logic [LEVEL_BITS-1:0] cfg_deadband;
    logic [LEVEL_BITS-1:0] cfg_precision;
    logic [LEVEL_BITS-1:0] cfg_cushion;
    logic [DELAY_BITS-1:0] cfg_accel;
    logic [DELAY_BITS-1:0] cfg_base_delay;
    logic [DELAY_BITS-1:0] cfg_min_pulse;

    // Follower state copies
    t_motion               fol_state;
    bit                    fol_near_start;
    bit                    fol_near_end;
    logic [LEVEL_BITS-1:0] fol_start;
    logic [LEVEL_BITS-1:0] fol_end;
    int                    fol_delay;

    t_decision pending_decisions[$];
    int        mismatch_count;
    int        items_sent;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        long_hold_cycles;
    bit        holding;

    always #1 i_clk = ~i_clk;

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void refresh_zones(input logic [LEVEL_BITS-1:0] pos);
        fol_near_start = magnitude(int'(pos) - int'(fol_start)) <= int'(cfg_cushion);
        fol_near_end   = magnitude(int'(pos) - int'(fol_end)) <= int'(cfg_cushion);
    endfunction

    // Advance the follower by one sample and return the decision it makes
    function automatic t_decision follow_sample(input logic [LEVEL_BITS-1:0] order,
                                                input logic [LEVEL_BITS-1:0] pos);
        t_decision d;
        int        diff;
        int        room;
        diff = int'(order) - int'(pos);
        if (diff > int'(cfg_deadband)) begin
            fol_state = ST_CW;
            refresh_zones(pos);
        end else if (diff < -int'(cfg_deadband)) begin
            fol_state = ST_CCW;
            refresh_zones(pos);
        end else begin
            // Inside the band: keep the zone flags, go idle within precision or else keep the state, latch the ends
            if (magnitude(diff) <= int'(cfg_precision)) fol_state = ST_IDLE;
            fol_start = pos;
            fol_end   = order;
        end

        d.pulse  = 1'b0;
        d.enable = 1'b0;
        d.half   = '0;
        if (fol_state == ST_IDLE) begin
            fol_delay = int'(cfg_base_delay);
        end else begin
            d.enable = 1'b1;
            d.pulse  = 1'b1;
            if (fol_near_start) begin
                fol_delay = (fol_delay > int'(cfg_accel)) ? fol_delay - int'(cfg_accel) : 0;
            end else if (fol_near_end) begin
                room = DELAY_MAX - fol_delay;
                fol_delay = (int'(cfg_accel) >= room) ? DELAY_MAX
                                                       : fol_delay + int'(cfg_accel);
            end
            d.half = (fol_delay <= int'(cfg_min_pulse)) ? cfg_base_delay
                                                        : DELAY_BITS'(fol_delay);
        end
        d.motion = fol_state;
        d.cw     = (fol_state == ST_CW);
        d.diff   = (LEVEL_BITS + 1)'(diff);
        return d;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        // Keep the log readable on a badly broken build; every mismatch still counts
        if (mismatch_count < PRINT_CAP)
            $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Check every result beat against the oldest pending decision
    always @(posedge i_clk) begin
        t_decision want;
        if (i_rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
            if (pending_decisions.size() == 0) begin
                report_mismatch("result beat with nothing pending", 1, 0);
            end else begin
                want = pending_decisions.pop_front();
                if (result_ch.motion_state !== want.motion)
                    report_mismatch("motion_state", result_ch.motion_state, want.motion);
                if (result_ch.direction_cw !== want.cw)
                    report_mismatch("direction_cw", result_ch.direction_cw, want.cw);
                if (result_ch.driver_enable !== want.enable)
                    report_mismatch("driver_enable", result_ch.driver_enable, want.enable);
                if (result_ch.step_pulse !== want.pulse)
                    report_mismatch("step_pulse", result_ch.step_pulse, want.pulse);
                if (result_ch.half_period !== want.half)
                    report_mismatch("half_period", result_ch.half_period, want.half);
                if (result_ch.level_difference !== want.diff)
                    report_mismatch("level_difference", $signed(result_ch.level_difference),
                                    $signed(want.diff));
            end
        end
    end

    // Receiver: random stalls, or a long hold-off while one is requested
    always @(negedge i_clk) begin
        result_ch.ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end

    // Count out a requested hold-off on the result side
    always begin
        wait (long_hold_cycles > 0);
        holding = 1'b1;
        repeat (long_hold_cycles) @(posedge i_clk);
        long_hold_cycles = 0;
        holding = 1'b0;
    end

    // Write one register; called at a falling edge, returns at one with the
    // write strobe already dropped
    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= DELAY_BITS'(value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_DEADBAND:     cfg_deadband   = LEVEL_BITS'(value);
            REG_PRECISION:    cfg_precision  = LEVEL_BITS'(value);
            REG_CUSHION:      cfg_cushion    = LEVEL_BITS'(value);
            REG_ACCELERATION: cfg_accel      = DELAY_BITS'(value);
            REG_BASE_DELAY:   cfg_base_delay = DELAY_BITS'(value);
            REG_MIN_PULSE:    cfg_min_pulse  = DELAY_BITS'(value);
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Send one sample pair beat and record the decision it must produce
    task automatic send_sample(input int order, input int pos);
        while ($urandom_range(99) < send_idle_pct) begin
            sample_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        sample_ch.valid          <= 1'b1;
        sample_ch.order_level    <= LEVEL_BITS'(order);
        sample_ch.position_level <= LEVEL_BITS'(pos);
        @(posedge i_clk);
        while (sample_ch.ready !== 1'b1) @(posedge i_clk);
        pending_decisions.push_back(follow_sample(LEVEL_BITS'(order), LEVEL_BITS'(pos)));
        items_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every pending decision has come back
    task automatic settle_pipeline();
        sample_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_decisions.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic restore_defaults();
        settle_pipeline();
        write_register(REG_DEADBAND, DEADBAND_RST);
        write_register(REG_PRECISION, PRECISION_RST);
        write_register(REG_CUSHION, CUSHION_RST);
        write_register(REG_ACCELERATION, ACCELERATION_RST);
        write_register(REG_BASE_DELAY, BASE_DELAY_RST);
        write_register(REG_MIN_PULSE, MIN_PULSE_RST);
    endtask

    task automatic pick_follow_settings(input int kind);
        int db;
        settle_pipeline();
        case (kind)
            SET_FAST_RAMP: begin
                write_register(REG_DEADBAND, 0);
                write_register(REG_PRECISION, 0);
                write_register(REG_CUSHION, LEVEL_MAX);
                write_register(REG_ACCELERATION, DELAY_MAX);
                write_register(REG_BASE_DELAY, DELAY_MAX);
                write_register(REG_MIN_PULSE, 0);
            end
            SET_FLAT_RAMP: begin
                write_register(REG_DEADBAND, 0);
                write_register(REG_PRECISION, 0);
                write_register(REG_CUSHION, 0);
                write_register(REG_ACCELERATION, 0);
                write_register(REG_BASE_DELAY, 0);
                write_register(REG_MIN_PULSE, DELAY_MAX);
            end
            default: begin
                db = $urandom_range(60);
                write_register(REG_DEADBAND, db);
                write_register(REG_PRECISION, $urandom_range(db));
                write_register(REG_CUSHION, $urandom_range(200));
                write_register(REG_ACCELERATION, $urandom_range(400));
                write_register(REG_BASE_DELAY, $urandom_range(5000, 200));
                write_register(REG_MIN_PULSE, $urandom_range(300));
            end
        endcase
    endtask

    // Mostly follow runs: the position walks toward a commanded level and settles;
    // the rest are unrelated sample pairs
    task automatic run_follow_items(input int count);
        int stop_at;
        int order;
        int pos;
        int gap;
        int stride;
        int steps;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 20) begin
                send_sample(LEVEL_BITS'($urandom), LEVEL_BITS'($urandom));
            end else begin
                order = $urandom_range(LEVEL_MAX);
                pos   = $urandom_range(LEVEL_MAX);
                steps = $urandom_range(60, 4);
                for (int k = 0; k < steps && items_sent < stop_at; k++) begin
                    send_sample(LEVEL_BITS'(order), LEVEL_BITS'(pos));
                    gap    = order - pos;
                    stride = $urandom_range(48, 1);
                    if (gap > 0) pos += (stride < gap) ? stride : gap;
                    else if (gap < 0) pos -= (stride < -gap) ? stride : -gap;
                    // Let the command wander a little now and then
                    if ($urandom_range(9) == 0) begin
                        order += $urandom_range(20) - 10;
                        if (order < 0) order = 0;
                        if (order > LEVEL_MAX) order = LEVEL_MAX;
                    end
                end
            end
        end
    endtask

    task automatic test_level_extremes();
        send_sample(0, 0);
        send_sample(LEVEL_MAX, 0);
        send_sample(0, LEVEL_MAX);
        send_sample(LEVEL_MAX, LEVEL_MAX);
        send_sample(512, 500);
    endtask

    task automatic test_band_and_cushions();
        send_sample(100, 90);   // latch ends while idle
        send_sample(200, 95);   // both zones: start wins, shorten
        send_sample(200, 150);  // end zone only: lengthen
        send_sample(180, 170);  // band while moving: keep state and flags
        send_sample(175, 172);  // within precision: idle, reload
        send_sample(0, 300);    // counter-clockwise outside both zones
    endtask

    task automatic test_delay_limits();
        settle_pipeline();
        write_register(REG_ACCELERATION, DELAY_MAX);
        send_sample(0, 200);    // delay floors at zero, small pulse uses base
        settle_pipeline();
        write_register(REG_BASE_DELAY, 300);
        send_sample(60, 50);    // base change shows in the pulse, not the stored delay
        send_sample(55, 52);    // idle reloads the new base
        settle_pipeline();
        write_register(REG_CUSHION, 0);
        send_sample(700, 690);
        send_sample(900, 700);  // end zone only: saturate at the top
        send_sample(900, 700);
        settle_pipeline();
        write_register(REG_MIN_PULSE, DELAY_MAX);
        send_sample(900, 700);  // every delay counts as a small pulse
    endtask

    task automatic test_register_index();
        settle_pipeline();
        write_register(REG_SPARE_LO, 16'hFFFF);
        write_register(REG_SPARE_HI, 16'h0000);
        write_register(REG_DEADBAND, 16'hFFFF);
        write_register(REG_PRECISION, 16'hFC00);
        send_sample(LEVEL_MAX, 0);
        send_sample(0, LEVEL_MAX);
        send_sample(512, 512);
        restore_defaults();
    endtask

    task automatic test_random_follow();
        send_idle_pct = 25; recv_stall_pct = 82;
        pick_follow_settings(SET_MODERATE);
        run_follow_items(290);
        pick_follow_settings(SET_FAST_RAMP);
        run_follow_items(290);
        send_idle_pct = 82; recv_stall_pct = 25;
        pick_follow_settings(SET_MODERATE);
        run_follow_items(290);
        pick_follow_settings(SET_FLAT_RAMP);
        run_follow_items(290);
        send_idle_pct = 0; recv_stall_pct = 0;
        pick_follow_settings(SET_MODERATE);
        run_follow_items(290);
        pick_follow_settings(SET_MODERATE);
        run_follow_items(290);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0; recv_stall_pct = 0;
        pick_follow_settings(SET_MODERATE);
        // Hold the result side long enough for the input to back up
        long_hold_cycles = 120;
        run_follow_items(40);
        settle_pipeline();
        long_hold_cycles = 80;
        run_follow_items(40);
    endtask

    initial begin
        i_rst_n                  = 1'b0;
        i_cfg_we                 = 1'b0;
        i_cfg_idx                = '0;
        i_cfg_data               = '0;
        sample_ch.valid          = 1'b0;
        sample_ch.order_level    = '0;
        sample_ch.position_level = '0;
        result_ch.ready          = 1'b0;
        mismatch_count   = 0;
        items_sent       = 0;
        long_hold_cycles = 0;
        holding          = 1'b0;
        send_idle_pct    = 25;
        recv_stall_pct   = 82;

        cfg_deadband   = LEVEL_BITS'(DEADBAND_RST);
        cfg_precision  = LEVEL_BITS'(PRECISION_RST);
        cfg_cushion    = LEVEL_BITS'(CUSHION_RST);
        cfg_accel      = DELAY_BITS'(ACCELERATION_RST);
        cfg_base_delay = DELAY_BITS'(BASE_DELAY_RST);
        cfg_min_pulse  = DELAY_BITS'(MIN_PULSE_RST);
        fol_state      = ST_IDLE;
        fol_near_start = 1'b0;
        fol_near_end   = 1'b0;
        fol_start      = '0;
        fol_end        = '0;
        fol_delay      = BASE_DELAY_RST;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_level_extremes();
        test_band_and_cushions();
        test_delay_limits();
        test_register_index();
        test_random_follow();
        test_backpressure();

        settle_pipeline();
        repeat (5) @(negedge i_clk);
        if (pending_decisions.size() != 0)
            report_mismatch("decisions never returned", 0, pending_decisions.size());
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #1_000_000;
        $display("timeout: %0d decisions still pending", pending_decisions.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
